FILE: sv/qte_pkg.sv
`timescale 1ns / 1ps
package qte_pkg;

  localparam int CordicStages = 16;
  localparam int FracBits     = 14;
  localparam int VecW         = 36;   // CORDIC x/y datapath width
  localparam int AngW         = FracBits + 4;
  localparam int SqW          = 58;   // radicand width
  localparam int RootW        = 29;
  localparam int PitchLimit   = 11600;
  localparam int Atan2Limit   = 23100;

  // atan(2^-i) rounded at 14 fractional bits. The last stage's angle rounds to zero.
  function automatic logic [AngW-1:0] atan_tab(input int i);
    logic [AngW-1:0] r;
    r = '0;
    case (i)
      0:  r = AngW'(12868);
      1:  r = AngW'(7596);
      2:  r = AngW'(4014);
      3:  r = AngW'(2037);
      4:  r = AngW'(1023);
      5:  r = AngW'(512);
      6:  r = AngW'(256);
      7:  r = AngW'(128);
      8:  r = AngW'(64);
      9:  r = AngW'(32);
      10: r = AngW'(16);
      11: r = AngW'(8);
      12: r = AngW'(4);
      13: r = AngW'(2);
      14: r = AngW'(1);
      15: r = AngW'(0);
      default: r = '0;
    endcase
    return r;
  endfunction

  localparam logic [AngW-1:0] HalfPi = AngW'(25736);

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
    logic                   zero;
  } cordic_t;

endpackage

FILE: sv/qte_cordic.sv
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC, one stage per clock while en_i is high, with its own valid bits.
module qte_cordic
  import qte_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [VecW-1:0] y_i,
  input  logic signed [VecW-1:0] x_i,
  output logic                   valid_o,
  output logic signed [AngW-1:0] angle_o
);

  cordic_t pre_d;
  cordic_t stg_q [CordicStages+1];
  logic    vld_q [CordicStages+1];

  always_comb begin
    pre_d.zero = (x_i == '0) && (y_i == '0);
    pre_d.x    = x_i;
    pre_d.y    = y_i;
    pre_d.z    = '0;
    if (x_i[VecW-1]) begin
      if (!y_i[VecW-1]) begin
        pre_d.x = y_i;
        pre_d.y = -x_i;
        pre_d.z = HalfPi;
      end else begin
        pre_d.x = -y_i;
        pre_d.y = x_i;
        pre_d.z = -HalfPi;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= pre_d;
    end
  end

  for (genvar i = 0; i < CordicStages; i++) begin : g_stage
    cordic_t nxt;
    always_comb begin
      nxt = stg_q[i];
      if (!stg_q[i].y[VecW-1]) begin
        nxt.x = stg_q[i].x + (stg_q[i].y >>> i);
        nxt.y = stg_q[i].y - (stg_q[i].x >>> i);
        nxt.z = stg_q[i].z + atan_tab(i);
      end else begin
        nxt.x = stg_q[i].x - (stg_q[i].y >>> i);
        nxt.y = stg_q[i].y + (stg_q[i].x >>> i);
        nxt.z = stg_q[i].z - atan_tab(i);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[i+1] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[CordicStages];
  assign angle_o = stg_q[CordicStages].zero ? '0 : stg_q[CordicStages].z;

endmodule

FILE: sv/quaternion_to_euler_angles_unit.sv
`timescale 1ns / 1ps
// The result passes through 53 register stages from the accepting edge on
// (products 1, sums 1, radicand 1, square root 29, CORDIC 17, scaling 3, output 1).
// Throughput: one quaternion per cycle; every stage is a register slice that
// advances together, gated only by a full output register whose result is not taken.
// Reset clears all valid bits; datapath registers are not reset.
module quaternion_to_euler_angles_unit
  import qte_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               pitch_clamped_o
);

  localparam int SqDly = RootW;  // one root bit per stage
  localparam logic signed [VecW-1:0] OneQ28 = VecW'(64'sd268435456);

  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: products.
  logic v1_q;
  logic signed [31:0] wy_q, xz_q, yz_q, wx_q, xx_q, yy_q, xy_q, wz_q, zz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      wy_q <= quat_w_i * quat_y_i;
      xz_q <= quat_x_i * quat_z_i;
      yz_q <= quat_y_i * quat_z_i;
      wx_q <= quat_w_i * quat_x_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      xy_q <= quat_x_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      zz_q <= quat_z_i * quat_z_i;
    end
  end

  // Stage 2: sums, clamp.
  logic v2_q, clamp_q;
  logic signed [VecW-1:0] s_q, ry_q, rx_q, yy2_q, yx_q;
  logic signed [VecW-1:0] s_d;
  logic clamp_d;
  always_comb begin
    s_d = (VecW'(wy_q) - VecW'(xz_q)) <<< 1;
    clamp_d = 1'b0;
    if (s_d > OneQ28) begin
      s_d = OneQ28; clamp_d = 1'b1;
    end else if (s_d < -OneQ28) begin
      s_d = -OneQ28; clamp_d = 1'b1;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q     <= s_d;
      clamp_q <= clamp_d;
      ry_q    <= (VecW'(yz_q) + VecW'(wx_q)) <<< 1;
      rx_q    <= OneQ28 - ((VecW'(xx_q) + VecW'(yy_q)) <<< 1);
      yy2_q   <= (VecW'(xy_q) + VecW'(wz_q)) <<< 1;
      yx_q    <= OneQ28 - ((VecW'(yy_q) + VecW'(zz_q)) <<< 1);
    end
  end

  // Stage 3: s squared into the radicand 2^56 - s^2 (|s| <= 2^28).
  logic v3_q;
  logic [SqW-1:0] rad_q;
  logic signed [VecW-1:0] s3_q, ry3_q, rx3_q, yy3_q, yx3_q;
  logic clamp3_q;
  logic [28:0] s_mag;
  assign s_mag = s_q[VecW-1] ? 29'(-s_q) : 29'(s_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q    <= (SqW'(1) << 56) - (SqW'(s_mag) * SqW'(s_mag));
      s3_q     <= s_q; ry3_q <= ry_q; rx3_q <= rx_q;
      yy3_q    <= yy2_q; yx3_q <= yx_q; clamp3_q <= clamp_q;
    end
  end

  // Pipelined restoring square root, one result bit per stage.
  typedef struct packed {
    logic [SqW-1:0]         rem;
    logic [RootW-1:0]       root;
    logic signed [VecW-1:0] s, ry, rx, yy, yx;
    logic                   clamp;
  } sq_t;
  sq_t sq_q [SqDly+1];
  logic sv_q [SqDly+1];
  always_comb begin
    sq_q[0] = '{rem: rad_q, root: '0, s: s3_q, ry: ry3_q, rx: rx3_q,
                yy: yy3_q, yx: yx3_q, clamp: clamp3_q};
    sv_q[0] = v3_q;
  end
  for (genvar k = 0; k < SqDly; k++) begin : g_sqrt
    localparam int B = RootW - 1 - k;
    sq_t nxt;
    logic [SqW+1:0] trial;
    always_comb begin
      nxt = sq_q[k];
      trial = ((SqW+2)'(sq_q[k].root) << (B + 1)) + ((SqW+2)'(1) << (2 * B));
      if ((SqW+2)'(sq_q[k].rem) >= trial) begin
        nxt.rem  = sq_q[k].rem - SqW'(trial);
        nxt.root = sq_q[k].root | (RootW'(1) << B);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k+1] <= 1'b0;
      else if (en) sv_q[k+1] <= sv_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (en) sq_q[k+1] <= nxt;
    end
  end

  sq_t sqo;
  assign sqo = sq_q[SqDly];

  logic cv_p, cv_r, cv_y;
  logic signed [AngW-1:0] ang_p, ang_r, ang_y;

  qte_cordic u_pitch (.clk_i, .rst_ni, .en_i(en), .valid_i(sv_q[SqDly]),
    .y_i(sqo.s), .x_i(VecW'(sqo.root)), .valid_o(cv_p), .angle_o(ang_p));
  qte_cordic u_roll (.clk_i, .rst_ni, .en_i(en), .valid_i(sv_q[SqDly]),
    .y_i(sqo.ry), .x_i(sqo.rx), .valid_o(cv_r), .angle_o(ang_r));
  qte_cordic u_yaw (.clk_i, .rst_ni, .en_i(en), .valid_i(sv_q[SqDly]),
    .y_i(sqo.yy), .x_i(sqo.yx), .valid_o(cv_y), .angle_o(ang_y));

  // Clamp flag delay to line up with the CORDIC outputs.
  logic cl_q [CordicStages+1];
  for (genvar k = 0; k <= CordicStages; k++) begin : g_cl
    always_ff @(posedge clk_i) begin
      if (en) cl_q[k] <= (k == 0) ? sqo.clamp : cl_q[(k == 0) ? 0 : k - 1];
    end
  end

  // Scaling: |z|*36672, then divide by 5*2^14.
  // q = floor((m*36672 + 40960) / 81920): the 2^14 factor goes by a shift, then the
  // quotient by 5 comes from a multiply by ceil(2^18/5) and a shift by 18, which is
  // exact while the shifted value stays below 2^18.
  logic sc1_v_q, sc2_v_q, sc3_v_q;
  logic [2:0] sgn1_q, sgn2_q, sgn3_q;
  logic cl1_q, cl2_q, cl3_q;
  logic [AngW-1:0] mag [3];
  logic [33:0] n1_q [3];
  logic [18:0] t2_q [3];
  logic [40:0] p3_q [3];
  logic signed [AngW-1:0] angs [3];
  assign angs[0] = ang_p;
  assign angs[1] = ang_r;
  assign angs[2] = ang_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc1_v_q <= 1'b0; sc2_v_q <= 1'b0; sc3_v_q <= 1'b0; out_valid_o <= 1'b0;
    end else if (en) begin
      sc1_v_q <= cv_p & cv_r & cv_y;
      sc2_v_q <= sc1_v_q;
      sc3_v_q <= sc2_v_q;
      out_valid_o <= sc3_v_q;
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_sc
    assign mag[j] = angs[j][AngW-1] ? AngW'(-angs[j]) : AngW'(angs[j]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        sgn1_q[j] <= angs[j][AngW-1];
        n1_q[j]   <= 34'(mag[j]) * 34'd36672 + 34'd40960;
        // n / 2^14, quotient by 5 follows.
        t2_q[j]   <= 19'(n1_q[j] >> FracBits);
        sgn2_q[j] <= sgn1_q[j];
        p3_q[j]   <= 41'(t2_q[j]) * 41'd52429;
        sgn3_q[j] <= sgn2_q[j];
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      cl1_q <= cl_q[CordicStages]; cl2_q <= cl1_q; cl3_q <= cl2_q;
    end
  end

  function automatic logic signed [15:0] fin(input logic [40:0] p, input logic s,
                                             input int lim);
    logic [15:0] q;
    q = 16'(p >> 18);
    if (q > 16'(lim)) q = 16'(lim);
    return s ? -$signed(q) : $signed(q);
  endfunction

  logic signed [15:0] pf_d;
  assign pf_d = fin(p3_q[0], sgn3_q[0], PitchLimit);
  always_ff @(posedge clk_i) begin
    if (en) begin
      pitch_angle_o   <= 15'(pf_d);
      roll_angle_o    <= fin(p3_q[1], sgn3_q[1], Atan2Limit);
      yaw_angle_o     <= fin(p3_q[2], sgn3_q[2], Atan2Limit);
      pitch_clamped_o <= cl3_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(roll_angle_o))
    else $error("result changed under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cv_p == cv_r) && (cv_r == cv_y))
    else $error("CORDIC lanes out of step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_angle_o <= 15'sd11600) && (pitch_angle_o >= -15'sd11600))
    else $error("pitch out of range");

endmodule

FILE: bench/quaternion_to_euler_angles_unit_tb.sv
`timescale 1ns / 1ps
module quaternion_to_euler_angles_unit_tb;
  import qte_pkg::*;

  localparam longint CycleLimit = 2000000;
  localparam longint unsigned PiQ60 = 64'h3243F6A8885A308D;
  localparam longint OneQ28 = 64'sd1 <<< 28;

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] quat_w_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [14:0] pitch_angle_o;
  logic signed [15:0] roll_angle_o;
  logic signed [15:0] yaw_angle_o;
  logic pitch_clamped_o;

  euler_t angles_due[$];
  longint atan_step[CordicStages];
  longint half_pi_rad;
  int mismatches = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  quaternion_to_euler_angles_unit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Elementary angles, rounded from Q.62 down to the accumulator's precision.
  function automatic longint unsigned atan_pow2_q62(int i);
    longint sum;
    longint term;
    int k;
    int e;
    sum = 0;
    if (i == 0) return PiQ60;
    k = 0;
    forever begin
      e = i * (2 * k + 1);
      if (e > 62) break;
      term = longint'((64'd1 << (62 - e)) / longint'(2 * k + 1));
      sum = (k % 2 == 1) ? sum - term : sum + term;
      k++;
    end
    return longint'(sum);
  endfunction

  function automatic longint q62_to_rad(longint unsigned v);
    return longint'((v + (64'd1 << (61 - FracBits))) >> (62 - FracBits));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint t;
    longint xs;
    longint ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = half_pi_rad;
      end else begin
        x = -y; y = t; z = -half_pi_rad;
      end
    end
    for (int i = 0; i < CordicStages; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_step[i];
      end else begin
        x -= ys; y += xs; z -= atan_step[i];
      end
    end
    return z;
  endfunction

  function automatic longint rad_to_units(longint z, longint limit);
    longint unsigned m;
    longint unsigned den;
    longint q;
    m = (z < 0) ? -z : z;
    den = 64'd5 << FracBits;
    q = longint'((m * 36672 + den / 2) / den);
    if (q > limit) q = limit;
    return (z < 0) ? -q : q;
  endfunction

  function automatic euler_t euler_of(longint w, longint x, longint y, longint z);
    euler_t e;
    longint s;
    longint cs;
    s = 2 * (w * y - x * z);
    e.clamped = 1'b0;
    if (s > OneQ28) begin
      s = OneQ28; e.clamped = 1'b1;
    end else if (s < -OneQ28) begin
      s = -OneQ28; e.clamped = 1'b1;
    end
    cs = longint'(int_sqrt((64'd1 << 56) - longint'(s * s)));
    e.pitch = 15'(rad_to_units(vector_angle(s, cs), PitchLimit));
    e.roll = 16'(rad_to_units(vector_angle(2 * (y * z + w * x),
                                           OneQ28 - 2 * (x * x + y * y)), Atan2Limit));
    e.yaw = 16'(rad_to_units(vector_angle(2 * (x * y + w * z),
                                          OneQ28 - 2 * (y * y + z * z)), Atan2Limit));
    return e;
  endfunction

  // Predict on every accepted item and check every accepted result.
  always @(posedge clk_i) begin
    euler_t want;
    euler_t got;
    cycles <= cycles + 1;
    if (in_valid_i && in_ready_o)
      angles_due.push_back(euler_of(quat_w_i, quat_x_i, quat_y_i, quat_z_i));
    if (out_valid_o && out_ready_i) begin
      got = {pitch_angle_o, roll_angle_o, yaw_angle_o, pitch_clamped_o};
      if (angles_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = angles_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pitch %0d/%0d roll %0d/%0d yaw %0d/%0d clamp %0b/%0b",
                     want.pitch, got.pitch, want.roll, got.roll, want.yaw, got.yaw,
                     want.clamped, got.clamped);
        end
      end
    end
  end

  always @(posedge clk_i)
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i)
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end

  task automatic send_quat(int w, int x, int y, int z);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    quat_w_i <= 16'(w);
    quat_x_i <= 16'(x);
    quat_y_i <= 16'(y);
    quat_z_i <= 16'(z);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_unit_quat();
    real c[4];
    real n;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = ($itor($urandom_range(20000)) - 10000.0) / 10000.0;
      n += c[i] * c[i];
    end
    if (n < 1.0e-6) begin
      c[0] = 1.0; n = 1.0;
    end
    n = $sqrt(n);
    for (int i = 0; i < 4; i++) c[i] = c[i] / n * 16384.0;
    send_quat($rtoi(c[0]), $rtoi(c[1]), $rtoi(c[2]), $rtoi(c[3]));
  endtask

  task automatic test_directed();
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(32767, -32768, 32767, -32768);
    // Gimbal lock at both poles, and a little past the positive pole so the sine clamps.
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(11700, 0, 11700, 0);
    send_quat(11700, 11700, 0, -11700);
    // Cosine term negative with each sign of the sine term.
    send_quat(0, 16384, 0, 0);
    send_quat(1, 16384, 0, 0);
    send_quat(-1, 16384, 0, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(1, 0, 0, 16384);
    send_quat(-1, 0, 0, 16384);
    send_quat(11585, 11585, 0, 0);
    send_quat(11585, 0, 0, -11585);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(0, 0, 16384, 0);
    send_quat(1, 1, 1, 1);
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1: send_quat($urandom, $urandom, $urandom, $urandom);
        2: send_quat($urandom_range(12000, 11000), $urandom_range(600) - 300,
                     $urandom_range(12000, 11000), $urandom_range(600) - 300);
        default: send_unit_quat();
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < CordicStages; i++) atan_step[i] = q62_to_rad(atan_pow2_q62(i));
    half_pi_rad = q62_to_rad(PiQ60 * 2);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(175, 0, 0);
    test_random(175, 64, 0);
    test_random(175, 0, 64);
    test_random(175, 13, 13);
    in_valid_i <= 1'b0;
    recv_stall_pct = 0;
    while (angles_due.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && angles_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
